// ===== rtl/fdt_pkg.sv =====
// Shared widths, register map, reset values and control types for the frame delta tracker.
`default_nettype none

package fdt_pkg;

    localparam int FRAME_W  = 32;
    localparam int SCALE_W  = 24;
    localparam int FRAC_W   = 16;
    localparam int SCALED_W = 40;
    localparam int ACC_W    = 64;
    localparam int PROD_W   = FRAME_W + SCALE_W;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;
    localparam int REG_IDX_W = 1;

    // Register indexes, taken from paddr[2].
    localparam logic [REG_IDX_W-1:0] REG_MAX_FRAME_TIME = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_TIME_SCALE     = 1'b1;

    localparam logic [FRAME_W-1:0] MAX_FRAME_TIME_RST = 32'd100000;
    localparam logic [SCALE_W-1:0] TIME_SCALE_RST     = 24'd65536;

    typedef struct packed {
        logic accept;
        logic calc;
        logic mul;
        logic acc;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/fdt_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module fdt_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fdt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [fdt_pkg::DATA_W-1:0]  pwdata,
    output logic      [fdt_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic      [fdt_pkg::FRAME_W-1:0] o_max_frame_time,
    output logic      [fdt_pkg::SCALE_W-1:0] o_time_scale
);

    logic [fdt_pkg::FRAME_W-1:0]   r_max_frame_time;
    logic [fdt_pkg::SCALE_W-1:0]   r_time_scale;
    logic [fdt_pkg::REG_IDX_W-1:0] w_idx;
    logic                          w_wr;

    assign w_idx  = paddr[2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_time <= fdt_pkg::MAX_FRAME_TIME_RST;
            r_time_scale     <= fdt_pkg::TIME_SCALE_RST;
        end else if (w_wr) begin
            case (w_idx)
                fdt_pkg::REG_MAX_FRAME_TIME: begin
                    r_max_frame_time <= pwdata[fdt_pkg::FRAME_W-1:0];
                end
                fdt_pkg::REG_TIME_SCALE: begin
                    r_time_scale <= pwdata[fdt_pkg::SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            fdt_pkg::REG_MAX_FRAME_TIME: prdata = r_max_frame_time;
            fdt_pkg::REG_TIME_SCALE:
                prdata = {{(fdt_pkg::DATA_W-fdt_pkg::SCALE_W){1'b0}}, r_time_scale};
            default: prdata = '0;
        endcase
    end

    assign o_max_frame_time = r_max_frame_time;
    assign o_time_scale     = r_time_scale;

endmodule

`default_nettype wire

// ===== rtl/fdt_ctrl.sv =====
// Sequencing state machine: accept, update, divide and hand over one frame at a time.
`default_nettype none

module fdt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output fdt_pkg::t_cmd      o_cmd,
    input  wire fdt_pkg::t_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_MUL,
        S_ACC,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        n_out_valid    = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // The result waits here until the output register is free.
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // No beat is taken while reset is applied.
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("fdt_ctrl: second beat taken while a frame is in flight");
`endif

endmodule

`default_nettype wire

// ===== rtl/fdt_dp.sv =====
// Datapath: clamp, accumulators, scaling multiply, history ring and serial divider.
`default_nettype none

module fdt_dp #(
    parameter int WINDOW = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire fdt_pkg::t_cmd                i_cmd,
    output fdt_pkg::t_stat                    o_stat,
    input  wire logic [fdt_pkg::FRAME_W-1:0]  i_max_frame_time,
    input  wire logic [fdt_pkg::SCALE_W-1:0]  i_time_scale,
    input  wire logic [fdt_pkg::FRAME_W-1:0]  i_frame_time,
    output logic      [fdt_pkg::FRAME_W-1:0]  o_clamped_time,
    output logic      [fdt_pkg::ACC_W-1:0]    o_total_time,
    output logic      [fdt_pkg::SCALED_W-1:0] o_scaled_time,
    output logic      [fdt_pkg::ACC_W-1:0]    o_total_scaled_time,
    output logic      [fdt_pkg::FRAME_W-1:0]  o_average_time
);

    localparam int FW     = fdt_pkg::FRAME_W;
    localparam int AW     = fdt_pkg::ACC_W;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = FW + FILL_W;
    localparam int CNT_W  = $clog2(SUM_W);

    logic [FW-1:0]                   r_mem [WINDOW];
    logic [FW-1:0]                   r_raw;
    logic [FW-1:0]                   r_old;
    logic [FW-1:0]                   r_clamp;
    logic [fdt_pkg::SCALED_W-1:0]    r_scaled;
    logic [AW-1:0]                   r_wall;
    logic [AW-1:0]                   r_sacc;
    logic [SUM_W-1:0]                r_sum;
    logic [FILL_W-1:0]               r_fill;
    logic [SLOT_W-1:0]               r_slot;
    logic [SUM_W-1:0]                r_dvd;
    logic [FILL_W:0]                 r_rem;
    logic [CNT_W-1:0]                r_div_cnt;

    logic [FW-1:0]                   r_o_clamp;
    logic [AW-1:0]                   r_o_wall;
    logic [fdt_pkg::SCALED_W-1:0]    r_o_scaled;
    logic [AW-1:0]                   r_o_sacc;
    logic [FW-1:0]                   r_o_avg;

    logic                            w_full;
    logic [fdt_pkg::PROD_W-1:0]      w_prod;
    logic [AW:0]                     w_wall_sum;
    logic [AW:0]                     w_sacc_sum;
    logic [FILL_W:0]                 w_rem_sh;
    logic [FILL_W:0]                 w_rem_sub;
    logic                            w_qbit;

    assign w_full = (r_fill == FILL_W'(WINDOW));
    assign w_prod = {{fdt_pkg::SCALE_W{1'b0}}, r_clamp}
                  * {{FW{1'b0}}, i_time_scale};
    assign w_wall_sum = {1'b0, r_wall} + {{(AW-FW+1){1'b0}}, r_raw};
    assign w_sacc_sum = {1'b0, r_sacc}
                      + {{(AW-fdt_pkg::SCALED_W+1){1'b0}}, r_scaled};

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign w_rem_sh  = {r_rem[FILL_W-1:0], r_dvd[SUM_W-1]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_fill});
    assign w_rem_sub = w_rem_sh - {1'b0, r_fill};

    assign o_stat.div_last = (r_div_cnt == CNT_W'(SUM_W - 1));

    // History ring: the oldest entry is read when a frame arrives.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_old <= r_mem[r_slot];
        end
        if (i_cmd.mul) begin
            r_mem[r_slot] <= r_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall <= '0;
            r_sacc <= '0;
            r_sum  <= '0;
            r_fill <= '0;
            r_slot <= '0;
        end else begin
            if (i_cmd.calc) begin
                r_wall <= w_wall_sum[AW] ? {AW{1'b1}} : w_wall_sum[AW-1:0];
                if (w_full) begin
                    r_sum <= r_sum - {{FILL_W{1'b0}}, r_old};
                end
            end
            if (i_cmd.mul) begin
                r_sum <= r_sum + {{FILL_W{1'b0}}, r_clamp};
                if (!w_full) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (r_slot == SLOT_W'(WINDOW - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            if (i_cmd.acc) begin
                r_sacc <= w_sacc_sum[AW] ? {AW{1'b1}} : w_sacc_sum[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_raw <= i_frame_time;
        end
        if (i_cmd.calc) begin
            r_clamp <= (r_raw < i_max_frame_time) ? r_raw : i_max_frame_time;
        end
        if (i_cmd.mul) begin
            r_scaled <= w_prod[fdt_pkg::FRAC_W +: fdt_pkg::SCALED_W];
        end
        if (i_cmd.acc) begin
            r_dvd     <= r_sum;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd     <= {r_dvd[SUM_W-2:0], w_qbit};
            r_rem     <= w_qbit ? w_rem_sub : w_rem_sh;
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_o_clamp  <= r_clamp;
            r_o_wall   <= r_wall;
            r_o_scaled <= r_scaled;
            r_o_sacc   <= r_sacc;
            r_o_avg    <= r_dvd[FW-1:0];
        end
    end

    assign o_clamped_time      = r_o_clamp;
    assign o_total_time        = r_o_wall;
    assign o_scaled_time       = r_o_scaled;
    assign o_total_scaled_time = r_o_sacc;
    assign o_average_time      = r_o_avg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW))
        else $error("fdt_dp: fill count beyond the window");

    a_wall_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_wall >= $past(r_wall)))
        else $error("fdt_dp: wall accumulator went backwards");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < {1'b0, r_fill}))
        else $error("fdt_dp: divider remainder not below the fill count");
`endif

endmodule

`default_nettype wire

// ===== rtl/frame_delta_tracker.sv =====
// Top level of the frame delta tracker: registers, controller and datapath.
//
//  channel  direction  handshake                 payload
//  in       sink       i_valid / o_ready         i_frame_time
//  out      source     o_valid / i_ready         o_clamped_time, o_total_time, o_scaled_time,
//                                                o_total_scaled_time, o_average_time
//  config   sink       psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// o_valid rises after the frame passes the calc, mul, acc, div and fin states, in that order;
// the one-bit-per-cycle average divider takes the bulk of this, and the next beat can be taken
// once the controller is back in idle.
// One frame is worked on at a time; the next beat is taken as soon as the previous
// result sits in the output register, even if that result has not yet been taken.
// Reset is synchronous and active low; o_ready is low during reset and the history
// ring needs no clearing pass.
// A stalled output holds the finished frame in the controller until the register frees.
`default_nettype none

module frame_delta_tracker #(
    parameter int WINDOW = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fdt_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [fdt_pkg::DATA_W-1:0]   pwdata,
    output logic      [fdt_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [fdt_pkg::FRAME_W-1:0]  i_frame_time,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [fdt_pkg::FRAME_W-1:0]  o_clamped_time,
    output logic      [fdt_pkg::ACC_W-1:0]    o_total_time,
    output logic      [fdt_pkg::SCALED_W-1:0] o_scaled_time,
    output logic      [fdt_pkg::ACC_W-1:0]    o_total_scaled_time,
    output logic      [fdt_pkg::FRAME_W-1:0]  o_average_time
);

    logic [fdt_pkg::FRAME_W-1:0] w_max_frame_time;
    logic [fdt_pkg::SCALE_W-1:0] w_time_scale;
    fdt_pkg::t_cmd               w_cmd;
    fdt_pkg::t_stat              w_stat;

    fdt_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_max_frame_time (w_max_frame_time),
        .o_time_scale     (w_time_scale)
    );

    fdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    fdt_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_max_frame_time    (w_max_frame_time),
        .i_time_scale        (w_time_scale),
        .i_frame_time        (i_frame_time),
        .o_clamped_time      (o_clamped_time),
        .o_total_time        (o_total_time),
        .o_scaled_time       (o_scaled_time),
        .o_total_scaled_time (o_total_scaled_time),
        .o_average_time      (o_average_time)
    );

endmodule

`default_nettype wire

// ===== tb/frame_delta_tracker_test.sv =====
// Self-checking testbench for the frame delta tracker: random and directed frames, APB setup.
`default_nettype none

module frame_delta_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW        = 16;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_FRAMES  = 120;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 60;

    typedef logic [fdt_pkg::FRAME_W-1:0]   t_frame;
    typedef logic [fdt_pkg::SCALE_W-1:0]   t_scale;
    typedef logic [fdt_pkg::SCALED_W-1:0]  t_scaled;
    typedef logic [fdt_pkg::ACC_W-1:0]     t_word;
    typedef logic [fdt_pkg::PROD_W-1:0]    t_prod;
    typedef logic [fdt_pkg::DATA_W-1:0]    t_data;
    typedef logic [fdt_pkg::ADDR_W-1:0]    t_addr;
    typedef logic [fdt_pkg::REG_IDX_W-1:0] t_idx;

    typedef struct {
        t_frame  clamped;
        t_word   total;
        t_scaled scaled;
        t_word   total_scaled;
        t_frame  average;
    } t_frame_result;

    // Tracks the clamp, both accumulators and the moving average, and holds the
    // results still owed by the block in arrival order.
    class t_frame_scoreboard;
        t_frame          max_frame_time;
        t_scale          time_scale;
        t_word           wall_total;
        t_word           scaled_total;
        t_frame          history [WINDOW];
        t_word           history_sum;
        int unsigned     held;
        int unsigned     slot;
        t_frame_result   owed [$];
        int unsigned     failures;
        int unsigned     reported;
        int unsigned     checked;

        function new();
            max_frame_time = fdt_pkg::MAX_FRAME_TIME_RST;
            time_scale     = fdt_pkg::TIME_SCALE_RST;
            wall_total     = '0;
            scaled_total   = '0;
            history_sum    = '0;
            held           = 0;
            slot           = 0;
            failures       = 0;
            reported       = 0;
            checked        = 0;
        endfunction

        function void write_reg(t_idx idx, t_data data);
            case (idx)
                fdt_pkg::REG_MAX_FRAME_TIME: max_frame_time = data;
                fdt_pkg::REG_TIME_SCALE:     time_scale = data[fdt_pkg::SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function t_data reg_value(t_idx idx);
            return (idx == fdt_pkg::REG_TIME_SCALE) ? t_data'(time_scale)
                                                    : t_data'(max_frame_time);
        endfunction

        function t_word sat_add(t_word a, t_word b);
            logic [fdt_pkg::ACC_W:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[fdt_pkg::ACC_W] ? '1 : sum[fdt_pkg::ACC_W-1:0];
        endfunction

        function void note_frame(t_frame raw);
            t_frame_result r;
            t_prod         product;
            r.clamped    = (raw < max_frame_time) ? raw : max_frame_time;
            wall_total   = sat_add(wall_total, t_word'(raw));
            product      = t_prod'(r.clamped) * t_prod'(time_scale);
            r.scaled     = t_scaled'(product >> fdt_pkg::FRAC_W);
            scaled_total = sat_add(scaled_total, t_word'(r.scaled));
            // Once the ring is full the oldest entry drops out of the sum.
            if (held >= WINDOW) begin
                history_sum -= t_word'(history[slot]);
            end else begin
                held++;
            end
            history[slot] = r.clamped;
            history_sum  += t_word'(r.clamped);
            slot          = (slot + 1) % WINDOW;
            r.total        = wall_total;
            r.total_scaled = scaled_total;
            r.average      = t_frame'(history_sum / t_word'(held));
            owed.insert(owed.size(), r);
        endfunction

        function void compare_field(string what, t_word want, t_word got);
            if (want !== got) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("mismatch in %s: expected %0h, got %0h", what, want, got);
                end
            end
        endfunction

        function void check_result(t_frame clamped, t_word total, t_scaled scaled,
                                   t_word total_scaled, t_frame average);
            t_frame_result r;
            if (owed.size() == 0) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("result beat with no frame outstanding at %0t", $realtime);
                end
                return;
            end
            r = owed.pop_front();
            checked++;
            compare_field("clamped_time", t_word'(r.clamped), t_word'(clamped));
            compare_field("total_time", r.total, total);
            compare_field("scaled_time", t_word'(r.scaled), t_word'(scaled));
            compare_field("total_scaled_time", r.total_scaled, total_scaled);
            compare_field("average_time", t_word'(r.average), t_word'(average));
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      psel = 1'b0;
    logic      penable = 1'b0;
    logic      pwrite = 1'b0;
    t_addr     paddr = '0;
    t_data     pwdata = '0;
    t_data     prdata;
    logic      pready;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_frame    i_frame_time = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_frame    o_clamped_time;
    t_word     o_total_time;
    t_scaled   o_scaled_time;
    t_word     o_total_scaled_time;
    t_frame    o_average_time;

    t_frame_scoreboard predictor = new();

    bit          calm = 1'b0;
    int unsigned ready_left = 0;
    int unsigned cycles = 0;
    int unsigned frames_sent = 0;
    int unsigned settings_used = 1;

    t_frame reset_cfg_frames [10] = '{
        32'd0, 32'd1, 32'd99999, 32'd100000, 32'd100001, 32'hFFFF_FFFF,
        32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd12345
    };
    t_frame zero_clamp_frames [3] = '{32'hFFFF_FFFF, 32'd1, 32'd0};
    t_frame wide_open_frames [6] = '{
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF
    };
    t_frame zero_scale_frames [2] = '{32'hFFFF_FFFF, 32'd1234};

    frame_delta_tracker #(
        .WINDOW(WINDOW)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_frame_time       (i_frame_time),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_clamped_time     (o_clamped_time),
        .o_total_time       (o_total_time),
        .o_scaled_time      (o_scaled_time),
        .o_total_scaled_time(o_total_scaled_time),
        .o_average_time     (o_average_time)
    );

    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycles, predictor.owed.size());
            $display("FAIL frame_delta_tracker");
            $finish;
        end
    end

    // The result side stalls in bursts; runs of ready vary so that stalls land
    // at every point of the block's iteration.
    always @(posedge i_clk) begin
        if (calm) begin
            i_ready <= 1'b1;
        end else if (ready_left != 0) begin
            ready_left--;
        end else if ($urandom_range(0, 3) == 0) begin
            i_ready <= 1'b0;
            ready_left = $urandom_range(1, 15);
        end else begin
            i_ready <= 1'b1;
            ready_left = $urandom_range(1, 60);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            predictor.check_result(o_clamped_time, o_total_time, o_scaled_time,
                                   o_total_scaled_time, o_average_time);
        end
    end

    task automatic read_back(input t_idx idx);
        t_data got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= t_addr'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        predictor.compare_field(idx == fdt_pkg::REG_TIME_SCALE ? "time_scale read"
                                                               : "max_frame_time read",
                                t_word'(predictor.reg_value(idx)), t_word'(got));
    endtask

    task automatic program_reg(input t_idx idx, input t_data data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= t_addr'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        predictor.write_reg(idx, data);
        @(posedge i_clk);
        read_back(idx);
    endtask

    task automatic send_frame(input t_frame frame_time);
        i_valid      <= 1'b1;
        i_frame_time <= frame_time;
        do @(posedge i_clk); while (!o_ready);
        predictor.note_frame(frame_time);
        frames_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Stop sending and hold off until every outstanding result has been taken.
    task automatic settle();
        i_valid <= 1'b0;
        while (predictor.owed.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_frame pick_frame();
        int unsigned k;
        k = $urandom_range(0, 31);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            4, 5, 6: return $urandom_range(0, 200000);
            7:       return predictor.max_frame_time + $urandom_range(0, 4) - 2;
            8:       return t_frame'(1) << k;
            default: return ~(t_frame'(1) << k);
        endcase
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_back(fdt_pkg::REG_MAX_FRAME_TIME);
        read_back(fdt_pkg::REG_TIME_SCALE);

        foreach (reset_cfg_frames[n]) send_frame(reset_cfg_frames[n]);
        settle();

        program_reg(fdt_pkg::REG_MAX_FRAME_TIME, '0);
        settings_used++;
        foreach (zero_clamp_frames[n]) send_frame(zero_clamp_frames[n]);
        settle();

        // Upper bits of the scale write must be dropped by the register.
        program_reg(fdt_pkg::REG_MAX_FRAME_TIME, '1);
        program_reg(fdt_pkg::REG_TIME_SCALE, 32'hFFFF_FFFF);
        settings_used++;
        foreach (wide_open_frames[n]) send_frame(wide_open_frames[n]);
        settle();

        program_reg(fdt_pkg::REG_TIME_SCALE, '0);
        settings_used++;
        foreach (zero_scale_frames[n]) send_frame(zero_scale_frames[n]);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: program_reg(fdt_pkg::REG_MAX_FRAME_TIME, $urandom_range(1000, 200000));
                1: program_reg(fdt_pkg::REG_MAX_FRAME_TIME, $urandom);
                2: program_reg(fdt_pkg::REG_MAX_FRAME_TIME, '1);
                default: program_reg(fdt_pkg::REG_MAX_FRAME_TIME, $urandom_range(0, 50));
            endcase
            case ($urandom_range(0, 4))
                0: program_reg(fdt_pkg::REG_TIME_SCALE, '0);
                1: program_reg(fdt_pkg::REG_TIME_SCALE, '1);
                2: program_reg(fdt_pkg::REG_TIME_SCALE, t_data'(fdt_pkg::TIME_SCALE_RST));
                default: program_reg(fdt_pkg::REG_TIME_SCALE, $urandom);
            endcase
            settings_used++;
            calm = (ph == RANDOM_PHASES - 1);
            repeat (PHASE_FRAMES) send_frame(pick_frame());
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d frames over %0d register settings, clamp and scale extremes included.",
                 frames_sent, settings_used);
        $display("Checked %0d results; %0d failures found.", predictor.checked, predictor.failures);
        if (predictor.failures == 0 && predictor.owed.size() == 0) begin
            $display("PASS frame_delta_tracker");
        end else begin
            $display("FAIL frame_delta_tracker");
        end
        $finish;
    end

endmodule

`default_nettype wire
